// ===== sv/assert_macros.svh =====
// Assertion macros shared by the view-matrix unit RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds around reset
`define ASSERT_NOW(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NOW(label, clk, prop, msg)
`endif
`endif

// ===== sv/evmu_pkg.sv =====
// Shared types, constants and tables of the view-matrix unit.
// No dependencies; used by every module of the block.
package evmu_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int TRIG_W       = FRAC_BITS + 2;   // holds -1.0 .. +1.0 with margin
   localparam int CW           = 34;              // CORDIC x/y/z width, Q30 plus growth
   localparam int PROD_W       = 64;
   localparam int ACC_W        = 66;
   localparam int SCALE_SH     = 32 + FRAC_BITS - ANGLE_BITS;
   localparam int MAC_STEPS    = 23;
   localparam int MAC_DRAIN    = 3;
   localparam int MAC_CNT_W    = $clog2(MAC_STEPS + MAC_DRAIN);

   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
   localparam logic signed [31:0]   DEG_SCALE   = 32'sd11930465;
   localparam logic signed [31:0]   RAD_SCALE   = 32'sd683565276;
   localparam logic signed [31:0]   ONE_FIX     = 32'sh1 << FRAC_BITS;

   typedef enum logic [2:0] {
      CMD_SET_ANGLE = 3'd0,
      CMD_ADD_ANGLE = 3'd1,
      CMD_SET_POS   = 3'd2,
      CMD_ADD_POS   = 3'd3,
      CMD_APPLY     = 3'd4
   } cmd_code_type;

   localparam logic [1:0] AXIS_Z = 2'd2;   // highest valid axis
   localparam logic [3:0] ENTRY_LAST = 4'd15;

   typedef enum logic [4:0] {
      SRC_ZERO  = 5'd0,
      SRC_SX    = 5'd1,
      SRC_CX    = 5'd2,
      SRC_SY    = 5'd3,
      SRC_CY    = 5'd4,
      SRC_SZ    = 5'd5,
      SRC_CZ    = 5'd6,
      SRC_T01   = 5'd7,
      SRC_T02   = 5'd8,
      SRC_T11   = 5'd9,
      SRC_T12   = 5'd10,
      SRC_R00   = 5'd11,
      SRC_R02   = 5'd12,
      SRC_R10   = 5'd13,
      SRC_R12   = 5'd14,
      SRC_R20   = 5'd15,
      SRC_R22   = 5'd16,
      SRC_P0    = 5'd17,
      SRC_P1    = 5'd18,
      SRC_P2    = 5'd19,
      SRC_OPND  = 5'd20,
      SRC_SCALE = 5'd21
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE = 4'd0,
      DST_T01  = 4'd1,
      DST_T02  = 4'd2,
      DST_T11  = 4'd3,
      DST_T12  = 4'd4,
      DST_R00  = 4'd5,
      DST_R02  = 4'd6,
      DST_R10  = 4'd7,
      DST_R12  = 4'd8,
      DST_R20  = 4'd9,
      DST_R22  = 4'd10,
      DST_TR0  = 4'd11,
      DST_TR1  = 4'd12,
      DST_TR2  = 4'd13
   } dst_type;

   typedef struct packed {
      logic    valid;
      src_type a_sel;
      src_type b_sel;
      logic    neg;     // negate the A operand
      logic    first;   // restart the accumulator
      dst_type dst;     // non-NONE on the last term of a sum
   } mac_op_type;

   typedef struct packed {
      logic              latch_req;
      logic              pos_write;
      logic              pos_add;
      logic              angle_write;
      logic              angle_add;
      logic              cordic_init;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              cordic_fin;
      mac_op_type        mac;
      logic              emit_load;
      logic [3:0]        emit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   localparam mac_op_type MAC_IDLE = '{1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE};

   function automatic mac_op_type mk_op(input src_type a, input src_type b,
                                        input logic neg, input logic first,
                                        input dst_type dst);
      mac_op_type o;
      o.valid = 1'b1;
      o.a_sel = a;
      o.b_sel = b;
      o.neg   = neg;
      o.first = first;
      o.dst   = dst;
      return o;
   endfunction

   // Rz*Rx, then (Rz*Rx)*Ry, then -(R*position); each sum rounded once.
   function automatic mac_op_type mac_step(input logic [MAC_CNT_W-1:0] s);
      mac_op_type o;
      o = MAC_IDLE;
      case (s)
         5'd0:  o = mk_op(SRC_SZ,  SRC_CX, 1'b1, 1'b1, DST_T01);
         5'd1:  o = mk_op(SRC_SZ,  SRC_SX, 1'b0, 1'b1, DST_T02);
         5'd2:  o = mk_op(SRC_CZ,  SRC_CX, 1'b0, 1'b1, DST_T11);
         5'd3:  o = mk_op(SRC_CZ,  SRC_SX, 1'b1, 1'b1, DST_T12);
         5'd4:  o = mk_op(SRC_CX,  SRC_SY, 1'b1, 1'b1, DST_R20);
         5'd5:  o = mk_op(SRC_CX,  SRC_CY, 1'b0, 1'b1, DST_R22);
         5'd6:  o = mk_op(SRC_CZ,  SRC_CY, 1'b0, 1'b1, DST_NONE);
         5'd7:  o = mk_op(SRC_T02, SRC_SY, 1'b1, 1'b0, DST_R00);
         5'd8:  o = mk_op(SRC_CZ,  SRC_SY, 1'b0, 1'b1, DST_NONE);
         5'd9:  o = mk_op(SRC_T02, SRC_CY, 1'b0, 1'b0, DST_R02);
         5'd10: o = mk_op(SRC_SZ,  SRC_CY, 1'b0, 1'b1, DST_NONE);
         5'd11: o = mk_op(SRC_T12, SRC_SY, 1'b1, 1'b0, DST_R10);
         5'd12: o = mk_op(SRC_SZ,  SRC_SY, 1'b0, 1'b1, DST_NONE);
         5'd13: o = mk_op(SRC_T12, SRC_CY, 1'b0, 1'b0, DST_R12);
         5'd14: o = mk_op(SRC_R00, SRC_P0, 1'b1, 1'b1, DST_NONE);
         5'd15: o = mk_op(SRC_T01, SRC_P1, 1'b1, 1'b0, DST_NONE);
         5'd16: o = mk_op(SRC_R02, SRC_P2, 1'b1, 1'b0, DST_TR0);
         5'd17: o = mk_op(SRC_R10, SRC_P0, 1'b1, 1'b1, DST_NONE);
         5'd18: o = mk_op(SRC_T11, SRC_P1, 1'b1, 1'b0, DST_NONE);
         5'd19: o = mk_op(SRC_R12, SRC_P2, 1'b1, 1'b0, DST_TR1);
         5'd20: o = mk_op(SRC_R20, SRC_P0, 1'b1, 1'b1, DST_NONE);
         5'd21: o = mk_op(SRC_SX,  SRC_P1, 1'b1, 1'b0, DST_NONE);
         5'd22: o = mk_op(SRC_R22, SRC_P2, 1'b1, 1'b0, DST_TR2);
         default: o = MAC_IDLE;
      endcase
      return o;
   endfunction

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [CW-1:0] atan_turn(input logic [ITER_W-1:0] i);
      logic signed [CW-1:0] v;
      v = '0;
      case (i)
         5'd0:  v = CW'(536870912);
         5'd1:  v = CW'(316933406);
         5'd2:  v = CW'(167458907);
         5'd3:  v = CW'(85004756);
         5'd4:  v = CW'(42667331);
         5'd5:  v = CW'(21354465);
         5'd6:  v = CW'(10679838);
         5'd7:  v = CW'(5340245);
         5'd8:  v = CW'(2670163);
         5'd9:  v = CW'(1335087);
         5'd10: v = CW'(667544);
         5'd11: v = CW'(333772);
         5'd12: v = CW'(166886);
         5'd13: v = CW'(83443);
         5'd14: v = CW'(41722);
         5'd15: v = CW'(20861);
         5'd16: v = CW'(10430);
         5'd17: v = CW'(5215);
         5'd18: v = CW'(2608);
         5'd19: v = CW'(1304);
         5'd20: v = CW'(652);
         5'd21: v = CW'(326);
         5'd22: v = CW'(163);
         5'd23: v = CW'(81);
         5'd24: v = CW'(41);
         5'd25: v = CW'(20);
         5'd26: v = CW'(10);
         5'd27: v = CW'(5);
         5'd28: v = CW'(3);
         5'd29: v = CW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/evmu_cordic.sv =====
// One CORDIC rotation lane: sine and cosine of a binary angle, one step a cycle.
// Depends on evmu_pkg.
module evmu_cordic (
   input  logic                                clock,
   input  logic                                init,
   input  logic                                step,
   input  logic [evmu_pkg::ITER_W-1:0]         iter,
   input  logic                                fin,
   input  logic [evmu_pkg::ANGLE_BITS-1:0]     angle,
   output logic signed [evmu_pkg::TRIG_W-1:0]  sin_value,
   output logic signed [evmu_pkg::TRIG_W-1:0]  cos_value
);
   import evmu_pkg::*;

   localparam logic signed [CW-1:0] ONE_CW  = CW'(ONE_FIX);
   localparam logic signed [CW-1:0] RND_CW  = CW'(1) << (29 - FRAC_BITS);

   logic signed [CW-1:0]     x_ff, y_ff, z_ff;
   logic signed [CW-1:0]     x_in, y_in, z_in;
   logic                     flip_ff, flip_in;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff, sin_in, cos_in;
   logic [31:0]              u_raw, u_turn, u_fold;
   logic signed [CW-1:0]     dx, dy, xf, yf, xr, yr;

   function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > ONE_CW) begin
         r = TRIG_W'(ONE_CW);
      end else if (v < -ONE_CW) begin
         r = TRIG_W'(-ONE_CW);
      end else begin
         r = TRIG_W'(v);
      end
      return r;
   endfunction

   always_comb begin
      u_raw  = 32'(angle) << (32 - ANGLE_BITS);
      u_turn = u_raw + 32'h4000_0000;
      // second and third quadrant: rotate by a half turn, negate at the end
      u_fold = u_raw ^ {u_turn[31], 31'd0};
      dx     = y_ff >>> iter;
      dy     = x_ff >>> iter;
      xf     = flip_ff ? -x_ff : x_ff;
      yf     = flip_ff ? -y_ff : y_ff;
      xr     = (xf + RND_CW) >>> (30 - FRAC_BITS);
      yr     = (yf + RND_CW) >>> (30 - FRAC_BITS);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (init) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CW'(signed'(u_fold));
         flip_in = u_turn[31];
      end else if (step) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_turn(iter);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_turn(iter);
         end
      end
      if (fin) begin
         sin_in = clamp_unit(yr);
         cos_in = clamp_unit(xr);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign sin_value = sin_ff;
   assign cos_value = cos_ff;

endmodule

// ===== sv/evmu_datapath.sv =====
// Datapath: angle and position stores, three CORDIC lanes, the shared
// multiply-accumulate pipe and the result register. Depends on evmu_pkg, evmu_cordic.
module evmu_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  evmu_pkg::dp_cmd_type    dp_cmd,
   output evmu_pkg::dp_sts_type    dp_sts,
   input  logic [1:0]              req_axis,
   input  logic                    req_in_degrees,
   input  logic signed [31:0]      req_operand,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tlast,
   output logic [3:0]              rsp_tuser
);
   import evmu_pkg::*;
   `include "assert_macros.svh"

   localparam int MAT_W = TRIG_W;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SCALE_HALF = PROD_W'(1) << (SCALE_SH - 1);

   // latched request
   logic [1:0]           axis_ff;
   logic                 deg_ff;
   logic signed [31:0]   opnd_ff;

   logic [ANGLE_BITS-1:0] ang_ff [3];
   logic signed [31:0]    pos_ff [3];

   logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
   logic signed [MAT_W-1:0]  t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [MAT_W-1:0]  r00_ff, r02_ff, r10_ff, r12_ff, r20_ff, r22_ff;
   logic signed [31:0]       tr0_ff, tr1_ff, tr2_ff;

   mac_op_type               p_op_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [31:0]       a_val, b_val, a_op;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, rnd;
   dst_type                  a_dst_ff;
   logic signed [MAT_W-1:0]  rnd_mat;
   logic signed [31:0]       rnd_sat;

   logic signed [32:0]       pos_sum;
   logic signed [31:0]       pos_new;
   logic signed [PROD_W-1:0] scaled;
   logic [ANGLE_BITS-1:0]    ang_new;

   logic                     rsp_valid_ff;
   logic [31:0]              rsp_data_ff, emit_val;
   logic                     rsp_last_ff;
   logic [3:0]               rsp_idx_ff;

   // three lanes run in lock step
   evmu_cordic u_cordic_x (
      .clock(clock), .init(dp_cmd.cordic_init), .step(dp_cmd.cordic_step),
      .iter(dp_cmd.iter), .fin(dp_cmd.cordic_fin), .angle(ang_ff[0]),
      .sin_value(sx), .cos_value(cx));
   evmu_cordic u_cordic_y (
      .clock(clock), .init(dp_cmd.cordic_init), .step(dp_cmd.cordic_step),
      .iter(dp_cmd.iter), .fin(dp_cmd.cordic_fin), .angle(ang_ff[1]),
      .sin_value(sy), .cos_value(cy));
   evmu_cordic u_cordic_z (
      .clock(clock), .init(dp_cmd.cordic_init), .step(dp_cmd.cordic_step),
      .iter(dp_cmd.iter), .fin(dp_cmd.cordic_fin), .angle(ang_ff[2]),
      .sin_value(sz), .cos_value(cz));

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > ACC_W'(32'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < ACC_W'(32'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] src_value(input src_type sel);
      logic signed [31:0] v;
      case (sel)
         SRC_SX:    v = 32'(sx);
         SRC_CX:    v = 32'(cx);
         SRC_SY:    v = 32'(sy);
         SRC_CY:    v = 32'(cy);
         SRC_SZ:    v = 32'(sz);
         SRC_CZ:    v = 32'(cz);
         SRC_T01:   v = 32'(t01_ff);
         SRC_T02:   v = 32'(t02_ff);
         SRC_T11:   v = 32'(t11_ff);
         SRC_T12:   v = 32'(t12_ff);
         SRC_R00:   v = 32'(r00_ff);
         SRC_R02:   v = 32'(r02_ff);
         SRC_R10:   v = 32'(r10_ff);
         SRC_R12:   v = 32'(r12_ff);
         SRC_R20:   v = 32'(r20_ff);
         SRC_R22:   v = 32'(r22_ff);
         SRC_P0:    v = pos_ff[0];
         SRC_P1:    v = pos_ff[1];
         SRC_P2:    v = pos_ff[2];
         SRC_OPND:  v = opnd_ff;
         SRC_SCALE: v = deg_ff ? DEG_SCALE : RAD_SCALE;
         default:   v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      a_val   = src_value(dp_cmd.mac.a_sel);
      b_val   = src_value(dp_cmd.mac.b_sel);
      a_op    = dp_cmd.mac.neg ? -a_val : a_val;
      prod_in = PROD_W'(a_op) * PROD_W'(b_val);
      acc_in  = (p_op_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
      rnd     = (acc_ff + ACC_HALF) >>> FRAC_BITS;
      rnd_mat = MAT_W'(rnd);
      rnd_sat = sat32(rnd);
      pos_sum = 33'(pos_ff[req_axis]) + 33'(req_operand);
      if (!dp_cmd.pos_add) begin
         pos_new = req_operand;
      end else if (pos_sum[32] != pos_sum[31]) begin
         pos_new = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         pos_new = 32'(pos_sum);
      end
      // binary angle: round half up, keep the low ANGLE_BITS
      scaled  = prod_ff + SCALE_HALF;
      ang_new = scaled[SCALE_SH +: ANGLE_BITS];
   end

   always_comb begin
      case (dp_cmd.emit_idx)
         4'd0:    emit_val = 32'(r00_ff);
         4'd1:    emit_val = 32'(r10_ff);
         4'd2:    emit_val = 32'(r20_ff);
         4'd4:    emit_val = 32'(t01_ff);
         4'd5:    emit_val = 32'(t11_ff);
         4'd6:    emit_val = 32'(sx);
         4'd8:    emit_val = 32'(r02_ff);
         4'd9:    emit_val = 32'(r12_ff);
         4'd10:   emit_val = 32'(r22_ff);
         4'd12:   emit_val = tr0_ff;
         4'd13:   emit_val = tr1_ff;
         4'd14:   emit_val = tr2_ff;
         4'd15:   emit_val = ONE_FIX;
         default: emit_val = '0;   // bottom row
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.latch_req) begin
         axis_ff <= req_axis;
         deg_ff  <= req_in_degrees;
         opnd_ff <= req_operand;
      end
      if (dp_cmd.mac.valid) begin
         prod_ff <= prod_in;
      end
      if (p_op_ff.valid) begin
         acc_ff <= acc_in;
      end
      a_dst_ff <= p_op_ff.valid ? p_op_ff.dst : DST_NONE;
      case (a_dst_ff)
         DST_T01: t01_ff <= rnd_mat;
         DST_T02: t02_ff <= rnd_mat;
         DST_T11: t11_ff <= rnd_mat;
         DST_T12: t12_ff <= rnd_mat;
         DST_R00: r00_ff <= rnd_mat;
         DST_R02: r02_ff <= rnd_mat;
         DST_R10: r10_ff <= rnd_mat;
         DST_R12: r12_ff <= rnd_mat;
         DST_R20: r20_ff <= rnd_mat;
         DST_R22: r22_ff <= rnd_mat;
         DST_TR0: tr0_ff <= rnd_sat;
         DST_TR1: tr1_ff <= rnd_sat;
         DST_TR2: tr2_ff <= rnd_sat;
         default: ;
      endcase
      if (dp_cmd.emit_load) begin
         rsp_data_ff <= emit_val;
         rsp_idx_ff  <= dp_cmd.emit_idx;
         rsp_last_ff <= (dp_cmd.emit_idx == ENTRY_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff[0]    <= '0;
         ang_ff[1]    <= '0;
         ang_ff[2]    <= '0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
         p_op_ff      <= MAC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.pos_write) begin
            pos_ff[req_axis] <= pos_new;
         end
         if (dp_cmd.angle_write) begin
            ang_ff[axis_ff] <= dp_cmd.angle_add ? ang_ff[axis_ff] + ang_new : ang_new;
         end
         p_op_ff <= dp_cmd.mac;
         if (dp_cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign dp_sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_idx_ff;

   `ASSERT_CLK(a_emit_shows, clock, reset, dp_cmd.emit_load |=> rsp_tvalid, "loaded beat not shown")
   `ASSERT_CLK(a_last_idx, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tuser == ENTRY_LAST, "tlast off the final entry")
   `ASSERT_NOW(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

// ===== sv/evmu_ctrl.sv =====
// Controller: decodes commands and sequences scale, CORDIC, MAC and emit phases.
// Depends on evmu_pkg.
module evmu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_command,
   input  logic [1:0]            req_axis,
   output evmu_pkg::dp_cmd_type  dp_cmd,
   input  evmu_pkg::dp_sts_type  dp_sts
);
   import evmu_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCALE  = 7'b0000010,
      ST_ANGW   = 7'b0000100,
      ST_CORDIC = 7'b0001000,
      ST_CFIN   = 7'b0010000,
      ST_MAC    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type            st_ff, st_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic [MAC_CNT_W-1:0] step_ff, step_in;
   logic [3:0]           emit_ff, emit_in;
   logic                 add_ff, add_in;
   logic                 accept;

   assign req_tready = (st_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      st_in   = st_ff;
      iter_in = iter_ff;
      step_in = step_ff;
      emit_in = emit_ff;
      add_in  = add_ff;
      dp_cmd  = '0;
      dp_cmd.mac      = MAC_IDLE;
      dp_cmd.iter     = iter_ff;
      dp_cmd.emit_idx = emit_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.latch_req = 1'b1;
               case (cmd_code_type'(req_command))
                  CMD_SET_ANGLE, CMD_ADD_ANGLE: begin
                     if (req_axis <= AXIS_Z) begin
                        add_in = (cmd_code_type'(req_command) == CMD_ADD_ANGLE);
                        st_in  = ST_SCALE;
                     end
                  end
                  CMD_SET_POS, CMD_ADD_POS: begin
                     dp_cmd.pos_write = (req_axis <= AXIS_Z);
                     dp_cmd.pos_add   = (cmd_code_type'(req_command) == CMD_ADD_POS);
                  end
                  CMD_APPLY: begin
                     dp_cmd.cordic_init = 1'b1;
                     iter_in = '0;
                     st_in   = ST_CORDIC;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCALE: begin
            dp_cmd.mac = mk_op(SRC_OPND, SRC_SCALE, 1'b0, 1'b1, DST_NONE);
            st_in = ST_ANGW;
         end
         ST_ANGW: begin
            dp_cmd.angle_write = 1'b1;
            dp_cmd.angle_add   = add_ff;
            st_in = ST_IDLE;
         end
         ST_CORDIC: begin
            dp_cmd.cordic_step = 1'b1;
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               st_in = ST_CFIN;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_CFIN: begin
            dp_cmd.cordic_fin = 1'b1;
            step_in = '0;
            st_in   = ST_MAC;
         end
         ST_MAC: begin
            dp_cmd.mac = mac_step(step_ff);
            // extra cycles let the last sums drain through the MAC pipe
            if (step_ff == MAC_CNT_W'(MAC_STEPS + MAC_DRAIN - 1)) begin
               emit_in = '0;
               st_in   = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (dp_sts.out_free) begin
               dp_cmd.emit_load = 1'b1;
               if (emit_ff == ENTRY_LAST) begin
                  st_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         iter_ff <= '0;
         step_ff <= '0;
         emit_ff <= '0;
         add_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         iter_ff <= iter_in;
         step_ff <= step_in;
         emit_ff <= emit_in;
         add_ff  <= add_in;
      end
   end

   `ASSERT_CLK(a_emit_free, clock, reset, dp_cmd.emit_load |-> dp_sts.out_free, "beat loaded over a waiting result")
   `ASSERT_CLK(a_emit_end, clock, reset, (st_ff == ST_EMIT) && dp_cmd.emit_load && (emit_ff == ENTRY_LAST) |=> st_ff == ST_IDLE, "run did not end after the final entry")
   `ASSERT_CLK(a_step_range, clock, reset, (st_ff == ST_MAC) |-> step_ff <= MAC_CNT_W'(MAC_STEPS + MAC_DRAIN - 1), "MAC step out of range")

endmodule

// ===== sv/euler_view_matrix_unit_core.sv =====
// Top level of the Euler-angle view-matrix unit: controller plus datapath.
// Depends on evmu_pkg, evmu_ctrl, evmu_datapath.
//
//  channel  dir  handshake           payload
//  req      in   req_tvalid/tready   tdata: operand_value; tuser: command, axis, in_degrees
//  rsp      out  rsp_tvalid/tready   tdata: entry_value; tuser: entry_index; tlast: last_entry
//
// Set/add position: written when taken. Set/add angle: scale multiply, then wrap add.
// Apply: init, 30 CORDIC steps, a finish step and the MAC sequence, then 16 beats; the
//   single shared 32x32 multiplier and the CORDIC step loop set its length.
// Synchronous active-high reset zeroes the angle and position stores.
// rsp back-pressure stalls the emit phase; req is taken once the last beat is registered.
module euler_view_matrix_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_value
   input  logic [5:0]  req_tuser,   // [2:0] command, [4:3] axis, [5] in_degrees
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] entry_value
   output logic        rsp_tlast,
   output logic [3:0]  rsp_tuser    // [3:0] entry_index
);
   import evmu_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   evmu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser[2:0]),
      .req_axis    (req_tuser[4:3]),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts)
   );

   evmu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_sts         (dp_sts),
      .req_axis       (req_tuser[4:3]),
      .req_in_degrees (req_tuser[5]),
      .req_operand    (signed'(req_tdata)),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

endmodule

// ===== bench/evmu_checker.sv =====
// Checker for the view-matrix unit: watches req/rsp beats, predicts matrix entries.
// Depends on evmu_pkg for command codes and field widths.
`timescale 1ns / 100ps

module evmu_checker
   import evmu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [5:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [3:0]  rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          applies_seen
);

   typedef struct {
      logic [3:0]  idx;
      logic [31:0] val;
      logic        last;
   } entry_type;

   entry_type matrix_q[$];
   logic [ANGLE_BITS-1:0] angles[3];
   logic signed [31:0]    pos[3];

   localparam longint ONE = longint'(1) << FRAC_BITS;

   longint atans[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

   assign pending = matrix_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic longint rnd_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp1(input longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] bam(input logic signed [31:0] v,
                                                  input logic deg);
      logic [63:0] p;
      p = 64'(longint'(v)) * (deg ? 64'd11930465 : 64'd683565276);
      p += 64'd1 << (SCALE_SH - 1);
      return ANGLE_BITS'(p >> SCALE_SH);
   endfunction

   task automatic trig(input logic [ANGLE_BITS-1:0] a, output longint s, output longint c);
      logic [31:0] u;
      logic flip;
      longint x, y, z, dx, dy;
      u = 32'(a) << (32 - ANGLE_BITS);
      flip = (u + 32'h4000_0000) >= 32'h8000_0000;
      if (flip) u = u - 32'h8000_0000;
      z = longint'($signed(u));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atans[i];
         end else begin
            x += dx; y -= dy; z += atans[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = clamp1(rnd_shift(y, 30 - FRAC_BITS));
      c = clamp1(rnd_shift(x, 30 - FRAC_BITS));
   endtask

   task automatic predict_matrix();
      longint sx, cx, sy, cy, sz, cz, acc, v;
      longint rx[3][3], ry[3][3], rz[3][3], t[3][3], r[3][3], tr[3];
      entry_type e;
      trig(angles[0], sx, cx);
      trig(angles[1], sy, cy);
      trig(angles[2], sz, cz);
      rx = '{'{ONE, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
      ry = '{'{cy, 0, sy}, '{0, ONE, 0}, '{-sy, 0, cy}};
      rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, ONE}};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rz[i][k] * rx[k][j];
            t[i][j] = rnd_shift(acc, FRAC_BITS);
         end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += t[i][k] * ry[k][j];
            r[i][j] = rnd_shift(acc, FRAC_BITS);
         end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) acc += r[i][k] * longint'(pos[k]);
         tr[i] = sat32(rnd_shift(-acc, FRAC_BITS));
      end
      for (int col = 0; col < 4; col++)
         for (int row = 0; row < 4; row++) begin
            if (row == 3) v = (col == 3) ? ONE : 0;
            else if (col == 3) v = tr[row];
            else v = r[row][col];
            e.idx = 4'(col * 4 + row);
            e.val = v[31:0];
            e.last = (e.idx == ENTRY_LAST);
            matrix_q.push_back(e);
         end
   endtask

   always @(posedge clock) begin
      logic [2:0] cmd;
      logic [1:0] ax;
      entry_type e;
      if (reset) begin
         angles = '{default: '0};
         pos = '{default: '0};
         matrix_q.delete();
         fail_count = 0;
         applies_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (matrix_q.size() == 0) begin
               report("unexpected beat index", rsp_tuser, -1);
            end else begin
               e = matrix_q.pop_front();
               if (rsp_tuser !== e.idx) report("entry_index", rsp_tuser, e.idx);
               if (rsp_tdata !== e.val)
                  report("entry_value", $signed(rsp_tdata), $signed(e.val));
               if (rsp_tlast !== e.last) report("last_entry", rsp_tlast, e.last);
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = req_tuser[2:0];
            ax = req_tuser[4:3];
            if (cmd == CMD_APPLY) begin
               predict_matrix();
               applies_seen++;
            end else if (cmd < CMD_APPLY && ax <= AXIS_Z) begin
               case (cmd)
                  CMD_SET_ANGLE: angles[ax] = bam(req_tdata, req_tuser[5]);
                  CMD_ADD_ANGLE: angles[ax] = angles[ax] + bam(req_tdata, req_tuser[5]);
                  CMD_SET_POS:   pos[ax] = req_tdata;
                  default:       pos[ax] = 32'(sat32(longint'(pos[ax])
                                            + longint'($signed(req_tdata))));
               endcase
            end
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for euler_view_matrix_unit_core: clock, reset, stimulus, verdict.
// Depends on evmu_pkg, evmu_checker and the unit's RTL.
`timescale 1ns / 100ps

module tb;
   import evmu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [5:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [3:0]  rsp_tuser;
   int          fail_count, pending, applies_seen;
   int          beats_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   euler_view_matrix_unit_core u_dut (.*);

   evmu_checker u_chk (.*);

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // valid stays up across a zero gap; the caller drops it after the last beat
   task automatic send(input logic [2:0] cmd, input logic [1:0] ax, input logic deg,
                       input logic [31:0] opnd);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= opnd;
      req_tuser  <= {deg, ax, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   function automatic logic [31:0] rnd_val();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(0, 720) - 360)) << 16;
      endcase
   endfunction

   // Receiver: random stalls, with long runs of always-ready
   initial begin
      int mode;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 4);
         repeat ($urandom_range(20, 200)) begin
            rsp_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 9) > gap_len());
            @(negedge clock);
         end
      end
   end

   initial begin
      int wait_cyc;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, each command, degree/radian, axis three, unknown codes
      send(CMD_APPLY, 2'd0, 1'b0, 32'h0);
      send(CMD_SET_ANGLE, 2'd0, 1'b1, 32'd90 << 16);
      send(CMD_SET_ANGLE, 2'd1, 1'b0, 32'h0003_243f);
      send(CMD_SET_ANGLE, 2'd2, 1'b1, 32'h8000_0000);
      send(CMD_SET_POS, 2'd0, 1'b0, 32'h7fff_ffff);
      send(CMD_SET_POS, 2'd1, 1'b1, 32'h8000_0000);
      send(CMD_SET_POS, 2'd2, 1'b0, 32'h7fff_ffff);
      send(CMD_APPLY, 2'd3, 1'b1, 32'hffff_ffff);
      send(CMD_ADD_POS, 2'd0, 1'b0, 32'h7fff_ffff);
      send(CMD_ADD_POS, 2'd1, 1'b0, 32'h8000_0000);
      send(CMD_ADD_ANGLE, 2'd0, 1'b1, 32'd270 << 16);
      send(CMD_ADD_ANGLE, 2'd1, 1'b0, 32'h7fff_ffff);
      send(CMD_ADD_ANGLE, 2'd2, 1'b1, 32'hffff_ffff);
      send(CMD_SET_ANGLE, 2'd3, 1'b1, 32'd45 << 16);
      send(CMD_ADD_POS, 2'd3, 1'b0, 32'h1234_5678);
      send(3'd5, 2'd0, 1'b0, 32'h0);
      send(3'd7, 2'd2, 1'b1, 32'hffff_ffff);
      send(CMD_APPLY, 2'd1, 1'b0, 32'h0);
      send(CMD_SET_ANGLE, 2'd2, 1'b1, 32'd180 << 16);
      send(CMD_SET_POS, 2'd2, 1'b0, 32'h0001_0000);
      send(CMD_APPLY, 2'd2, 1'b1, 32'h5555_aaaa);
      // random: mostly updates followed by an apply
      while (beats_sent < 100) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send(CMD_APPLY, 2'($urandom()), 1'($urandom()), $urandom());
            3: send(3'($urandom_range(5, 7)), 2'($urandom()), 1'($urandom()), $urandom());
            default: send(3'($urandom_range(0, 3)), 2'($urandom()), 1'($urandom()),
                          rnd_val());
         endcase
      end
      req_tvalid <= 1'b0;
      wait_cyc = 0;
      while (pending != 0 && wait_cyc < 100000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (100) @(posedge clock);
      $display("tb: %0d request beats sent, %0d matrix applies checked", beats_sent,
               applies_seen);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
